// ===== hdl/drd_pkg.sv =====
// ---------------------------------------------------------------------------
// drd_pkg - datagram receive deframer shared definitions
// Item codes, result codes, parser phases and the reflected CRC-32 helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package drd_pkg;

  // Item kinds on the request channel
  typedef enum logic [1:0] {
    MODE_DATA  = 2'd0,
    MODE_START = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_ARM   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    RESP_OK        = 2'd0,
    RESP_NOT_ARMED = 2'd1,
    RESP_BUSY      = 2'd2,
    RESP_NO_DGRAM  = 2'd3
  } resp_t;

  typedef enum logic [1:0] {
    VERDICT_COMPLETE = 2'd0,
    VERDICT_SOFT     = 2'd1,
    VERDICT_CRC_BAD  = 2'd2,
    VERDICT_TIMEOUT  = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    LS_IDLE     = 2'd0,
    LS_ACTIVE   = 2'd1,
    LS_COMPLETE = 2'd2,
    LS_ERROR    = 2'd3
  } link_t;

  typedef enum logic [2:0] {
    PH_VERSION = 3'd0,
    PH_CRC     = 3'd1,
    PH_TYPE    = 3'd2,
    PH_DLEN    = 3'd3,
    PH_DEST    = 3'd4,
    PH_LEN     = 3'd5,
    PH_DATA    = 3'd6
  } phase_t;

  // Configuration register indexes
  localparam logic [1:0] REG_EXP_VERSION = 2'd0;
  localparam logic [1:0] REG_OWN_NODE    = 2'd1;
  localparam logic [1:0] REG_TIMEOUT     = 2'd2;

  localparam logic [7:0]  EXP_VERSION_RST = 8'd1;
  localparam logic [7:0]  OWN_NODE_RST    = 8'd0;
  localparam logic [15:0] TIMEOUT_RST     = 16'd25;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  typedef struct packed {
    logic [7:0]  exp_version;
    logic [7:0]  own_node;
    logic [15:0] timeout;
  } drd_cfg_t;

  typedef struct packed {
    resp_t       response;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        finished;
    verdict_t    verdict;
    logic [7:0]  frame_type;
    logic [7:0]  dest_count;
    logic [15:0] payload_length;
    logic [31:0] crc_word;
  } drd_result_t;

  // One byte of reflected CRC-32; pure XOR network
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Four bytes, least significant first
  function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] w);
    logic [31:0] c;
    c = crc_byte(crc, w[7:0]);
    c = crc_byte(c, w[15:8]);
    c = crc_byte(c, w[23:16]);
    c = crc_byte(c, w[31:24]);
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/datagram_receive_deframer.sv =====
// ---------------------------------------------------------------------------
// datagram_receive_deframer - byte-serial datagram receiver
// Parses armed, start-marked datagrams, passes payload bytes out and checks
// the carried CRC-32 at the end of each datagram.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake            Content
// request   in         in_valid / in_stall  mode, data_byte
// result    out        out_valid/out_stall  response, payload, end-of-datagram
// config    in         cfg_write_en         cfg_index, cfg_data
//
// Every request yields exactly one result, registered in the cycle after accept.
// One request per cycle: the parser state and the CRC updates settle
// combinationally, and the result register frees the input side while a result
// waits; in_stall is raised only when that register is full and stalled.
// rst (synchronous) disarms the receiver, idles the link and loads the
// register defaults: version 1, node id 0, timeout 25 ticks.
// ---------------------------------------------------------------------------
`default_nettype none

module datagram_receive_deframer
  import drd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  data_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       response,
  output logic             payload_valid,
  output logic [7:0]       payload_byte,
  output logic             finished,
  output logic [1:0]       verdict,
  output logic [7:0]       frame_type,
  output logic [7:0]       dest_count,
  output logic [15:0]      payload_length,
  output logic [31:0]      crc_word,
  // configuration
  input  wire logic        cfg_write_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  drd_cfg_t    cfg;
  drd_result_t res;
  drd_result_t res_q;
  logic        take;

  // accept whenever the result register is free or being emptied
  assign in_stall = out_valid & out_stall;
  assign take     = in_valid & ~in_stall;

  // configuration registers; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.exp_version <= EXP_VERSION_RST;
      cfg.own_node    <= OWN_NODE_RST;
      cfg.timeout     <= TIMEOUT_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_EXP_VERSION: cfg.exp_version <= cfg_data[7:0];
        REG_OWN_NODE:    cfg.own_node    <= cfg_data[7:0];
        REG_TIMEOUT:     cfg.timeout     <= cfg_data;
        default:         ;
      endcase
    end
  end

  drd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .mode      (mode),
    .data_byte (data_byte),
    .cfg       (cfg),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res;
    end
  end

  assign response       = res_q.response;
  assign payload_valid  = res_q.payload_valid;
  assign payload_byte   = res_q.payload_byte;
  assign finished       = res_q.finished;
  assign verdict        = res_q.verdict;
  assign frame_type     = res_q.frame_type;
  assign dest_count     = res_q.dest_count;
  assign payload_length = res_q.payload_length;
  assign crc_word       = res_q.crc_word;

endmodule

`default_nettype wire

// ===== hdl/drd_core.sv =====
// ---------------------------------------------------------------------------
// drd_core - datagram parser state and per-item result
// Holds the datagram state and forms the result of the presented item.
// ---------------------------------------------------------------------------
`default_nettype none

module drd_core
  import drd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  data_byte,
  input  wire drd_cfg_t    cfg,
  output drd_result_t      res
);

  logic        armed, armed_next;
  link_t       link_status, link_status_next;
  logic        soft_flag, soft_flag_next;
  phase_t      phase, phase_next;
  logic [15:0] field_count, field_count_next;
  logic [31:0] carried_crc, carried_crc_next;
  logic [7:0]  type_hold, type_hold_next;
  logic [7:0]  dest_len_hold, dest_len_hold_next;
  logic [15:0] length_hold, length_hold_next;
  logic        id_seen, id_seen_next;
  logic [31:0] dest_crc, dest_crc_next;
  logic [31:0] payload_crc, payload_crc_next;
  // running CRC over type, count, destination CRC and length
  logic [31:0] check_crc, check_crc_next;
  logic [15:0] idle_ticks, idle_ticks_next;

  // decisions handed to the output block
  resp_t       resp;
  logic        fin;
  verdict_t    fin_verdict;
  logic        pay_out;

  mode_t       m;
  logic [7:0]  b;
  logic [15:0] fc_inc;
  logic [15:0] tick_inc;
  logic [31:0] final_crc;

  assign m        = mode_t'(mode);
  assign b        = data_byte;
  assign fc_inc   = field_count + 16'd1;
  assign tick_inc = (idle_ticks == 16'hFFFF) ? idle_ticks : idle_ticks + 16'd1;

  // next state
  always_comb begin
    armed_next         = armed;
    link_status_next   = link_status;
    soft_flag_next     = soft_flag;
    phase_next         = phase;
    field_count_next   = field_count;
    carried_crc_next   = carried_crc;
    type_hold_next     = type_hold;
    dest_len_hold_next = dest_len_hold;
    length_hold_next   = length_hold;
    id_seen_next       = id_seen;
    dest_crc_next      = dest_crc;
    payload_crc_next   = payload_crc;
    check_crc_next     = check_crc;
    idle_ticks_next    = idle_ticks;
    final_crc          = 32'd0;
    resp               = RESP_OK;
    fin                = 1'b0;
    fin_verdict        = VERDICT_COMPLETE;
    pay_out            = 1'b0;

    if (m == MODE_ARM) begin
      if (link_status == LS_ACTIVE) begin
        resp = RESP_BUSY;
      end else begin
        armed_next = 1'b1;
      end
    end else if (!armed) begin
      resp = RESP_NOT_ARMED;
    end else if (m == MODE_START) begin
      if (link_status == LS_ACTIVE && !soft_flag) begin
        resp = RESP_BUSY;
      end else begin
        link_status_next   = LS_ACTIVE;
        soft_flag_next     = 1'b0;
        phase_next         = PH_VERSION;
        field_count_next   = 16'd0;
        carried_crc_next   = 32'd0;
        type_hold_next     = 8'd0;
        dest_len_hold_next = 8'd0;
        length_hold_next   = 16'd0;
        id_seen_next       = 1'b0;
        dest_crc_next      = CRC_INIT;
        payload_crc_next   = CRC_INIT;
        check_crc_next     = CRC_INIT;
        idle_ticks_next    = 16'd0;
      end
    end else if (link_status != LS_ACTIVE) begin
      resp = RESP_NO_DGRAM;
    end else if (soft_flag) begin
      // datagram already ended softly: drop silently
    end else if (m == MODE_TICK) begin
      idle_ticks_next = tick_inc;
      if (tick_inc >= cfg.timeout) begin
        armed_next       = 1'b0;
        link_status_next = LS_ERROR;
        fin              = 1'b1;
        fin_verdict      = VERDICT_TIMEOUT;
      end
    end else begin
      idle_ticks_next = 16'd0;
      case (phase)
        PH_VERSION: begin
          if (b != cfg.exp_version) begin
            soft_flag_next = 1'b1;
            fin            = 1'b1;
            fin_verdict    = VERDICT_SOFT;
          end else begin
            phase_next       = PH_CRC;
            field_count_next = 16'd0;
          end
        end
        PH_CRC: begin
          case (field_count[1:0])
            2'd0:    carried_crc_next[7:0]   = carried_crc[7:0]   | b;
            2'd1:    carried_crc_next[15:8]  = carried_crc[15:8]  | b;
            2'd2:    carried_crc_next[23:16] = carried_crc[23:16] | b;
            default: carried_crc_next[31:24] = carried_crc[31:24] | b;
          endcase
          field_count_next = fc_inc;
          if (fc_inc >= 16'd4) begin
            phase_next = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_hold_next = b;
          check_crc_next = crc_byte(CRC_INIT, b);
          phase_next     = PH_DLEN;
        end
        PH_DLEN: begin
          dest_len_hold_next = b;
          field_count_next   = 16'd0;
          id_seen_next       = 1'b0;
          check_crc_next     = crc_byte(check_crc, b);
          if (b == 8'd0) begin
            soft_flag_next = 1'b1;
            fin            = 1'b1;
            fin_verdict    = VERDICT_SOFT;
          end else begin
            phase_next = PH_DEST;
          end
        end
        PH_DEST: begin
          dest_crc_next    = crc_byte(dest_crc, b);
          id_seen_next     = id_seen | (b == cfg.own_node);
          field_count_next = fc_inc;
          if (fc_inc >= {8'd0, dest_len_hold}) begin
            if (!id_seen_next) begin
              soft_flag_next = 1'b1;
              fin            = 1'b1;
              fin_verdict    = VERDICT_SOFT;
            end else begin
              phase_next       = PH_LEN;
              field_count_next = 16'd0;
              check_crc_next   = crc_word(check_crc, ~dest_crc_next);
            end
          end
        end
        PH_LEN: begin
          check_crc_next = crc_byte(check_crc, b);
          if (field_count == 16'd0) begin
            length_hold_next = {8'd0, b};
            field_count_next = 16'd1;
          end else begin
            length_hold_next = {b, length_hold[7:0]};
            field_count_next = 16'd0;
            if (length_hold_next == 16'd0) begin
              armed_next = 1'b0;
              fin        = 1'b1;
              final_crc  = ~crc_word(check_crc_next, ~payload_crc_next);
              if (final_crc == carried_crc) begin
                link_status_next = LS_COMPLETE;
                fin_verdict      = VERDICT_COMPLETE;
              end else begin
                link_status_next = LS_ERROR;
                fin_verdict      = VERDICT_CRC_BAD;
              end
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        default: begin
          pay_out          = 1'b1;
          payload_crc_next = crc_byte(payload_crc, b);
          field_count_next = fc_inc;
          if (fc_inc >= length_hold) begin
            armed_next = 1'b0;
            fin        = 1'b1;
            final_crc  = ~crc_word(check_crc_next, ~payload_crc_next);
            if (final_crc == carried_crc) begin
              link_status_next = LS_COMPLETE;
              fin_verdict      = VERDICT_COMPLETE;
            end else begin
              link_status_next = LS_ERROR;
              fin_verdict      = VERDICT_CRC_BAD;
            end
          end
        end
      endcase
    end
  end

  // result of this item; held fields are shown only when it ends the datagram
  always_comb begin
    res                = '0;
    res.response       = resp;
    res.payload_valid  = pay_out;
    res.payload_byte   = pay_out ? b : 8'd0;
    res.finished       = fin;
    if (fin) begin
      res.verdict        = fin_verdict;
      res.frame_type     = type_hold_next;
      res.dest_count     = dest_len_hold_next;
      res.payload_length = length_hold_next;
      res.crc_word       = carried_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed         <= 1'b0;
      link_status   <= LS_IDLE;
      soft_flag     <= 1'b0;
      phase         <= PH_VERSION;
      field_count   <= 16'd0;
      carried_crc   <= 32'd0;
      type_hold     <= 8'd0;
      dest_len_hold <= 8'd0;
      length_hold   <= 16'd0;
      id_seen       <= 1'b0;
      dest_crc      <= CRC_INIT;
      payload_crc   <= CRC_INIT;
      check_crc     <= CRC_INIT;
      idle_ticks    <= 16'd0;
    end else if (take) begin
      armed         <= armed_next;
      link_status   <= link_status_next;
      soft_flag     <= soft_flag_next;
      phase         <= phase_next;
      field_count   <= field_count_next;
      carried_crc   <= carried_crc_next;
      type_hold     <= type_hold_next;
      dest_len_hold <= dest_len_hold_next;
      length_hold   <= length_hold_next;
      id_seen       <= id_seen_next;
      dest_crc      <= dest_crc_next;
      payload_crc   <= payload_crc_next;
      check_crc     <= check_crc_next;
      idle_ticks    <= idle_ticks_next;
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb - datagram receive deframer testbench
// Feeds arm, start, tick and data requests (whole datagrams with random
// content and injected faults, plus stray requests) through the request
// channel and compares every result against a cycle-free model of the
// deframer. The register settings change between traffic phases.
// ---------------------------------------------------------------------------

module tb;
  import drd_pkg::*;

  // Nothing accepted on either channel for this many cycles ends the run.
  // The longest legal quiet stretch is the HOLD_CYCLES sink hold-off.
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  // Kinds of damage a generated datagram can carry
  typedef enum {
    FLT_NONE,
    FLT_VERSION,   // wrong version byte: soft end
    FLT_NO_DEST,   // zero destination count: soft end on the count byte
    FLT_NOT_MINE,  // own node id missing from the list: soft end
    FLT_CRC,       // one bit of the carried CRC flipped: hard error
    FLT_TRUNCATE   // frame cut short, then ticks until timeout
  } fault_t;

  // -------------------------------------------------------------------------
  // Scoreboard: mirrors the deframer state, predicts one result per request
  // and checks results in order.
  // -------------------------------------------------------------------------
  class dgram_scoreboard;
    logic [7:0]  exp_version;
    logic [7:0]  own_node;
    logic [15:0] timeout_ticks;
    bit          armed;
    link_t       link;
    bit          soft_done;
    phase_t      ph;
    logic [15:0] fcount;
    logic [31:0] carried_crc;
    logic [7:0]  type_hold;
    logic [7:0]  dcount_hold;
    logic [15:0] length_hold;
    bit          id_seen;
    logic [31:0] dest_crc;
    logic [31:0] pay_crc;
    logic [15:0] idle_ticks;
    drd_result_t pending_results[$];
    int          mismatches;

    function new();
      exp_version   = EXP_VERSION_RST;
      own_node      = OWN_NODE_RST;
      timeout_ticks = TIMEOUT_RST;
      armed         = 1'b0;
      link          = LS_IDLE;
      soft_done     = 1'b0;
      mismatches    = 0;
      clear_dgram();
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == REG_EXP_VERSION) exp_version = val[7:0];
      else if (idx == REG_OWN_NODE) own_node = val[7:0];
      else if (idx == REG_TIMEOUT) timeout_ticks = val;
    endfunction

    // reflected CRC-32, one byte, LSB first
    function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      repeat (8) c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      return c;
    endfunction

    function logic [31:0] crc_le32(logic [31:0] crc, logic [31:0] w);
      logic [31:0] c;
      c = crc;
      for (int i = 0; i < 4; i++) c = crc_step(c, w[8*i +: 8]);
      return c;
    endfunction

    // CRC the frame must carry, from the running destination/payload CRCs
    function logic [31:0] frame_crc(logic [7:0] t, logic [7:0] n, logic [31:0] dcrc,
                                    logic [15:0] len, logic [31:0] pcrc);
      logic [31:0] c;
      c = crc_step(CRC_INIT, t);
      c = crc_step(c, n);
      c = crc_le32(c, ~dcrc);
      c = crc_step(c, len[7:0]);
      c = crc_step(c, len[15:8]);
      c = crc_le32(c, ~pcrc);
      return ~c;
    endfunction

    function void clear_dgram();
      ph          = PH_VERSION;
      fcount      = '0;
      carried_crc = '0;
      type_hold   = '0;
      dcount_hold = '0;
      length_hold = '0;
      id_seen     = 1'b0;
      dest_crc    = CRC_INIT;
      pay_crc     = CRC_INIT;
      idle_ticks  = '0;
    endfunction

    function void close_dgram(inout drd_result_t r, input verdict_t v);
      r.finished       = 1'b1;
      r.verdict        = v;
      r.frame_type     = type_hold;
      r.dest_count     = dcount_hold;
      r.payload_length = length_hold;
      r.crc_word       = carried_crc;
    endfunction

    function void soft_end(inout drd_result_t r);
      soft_done = 1'b1;
      close_dgram(r, VERDICT_SOFT);
    endfunction

    function void final_check(inout drd_result_t r);
      armed = 1'b0;
      if (frame_crc(type_hold, dcount_hold, dest_crc, length_hold, pay_crc) == carried_crc)
      begin
        link = LS_COMPLETE;
        close_dgram(r, VERDICT_COMPLETE);
      end else begin
        link = LS_ERROR;
        close_dgram(r, VERDICT_CRC_BAD);
      end
    endfunction

    // field parser, one data byte
    function void take_byte(logic [7:0] b, inout drd_result_t r);
      case (ph)
        PH_VERSION: begin
          if (b != exp_version) soft_end(r);
          else begin
            ph     = PH_CRC;
            fcount = '0;
          end
        end
        PH_CRC: begin
          carried_crc = carried_crc | ({24'd0, b} << (8 * fcount[1:0]));
          fcount++;
          if (fcount >= 16'd4) ph = PH_TYPE;
        end
        PH_TYPE: begin
          type_hold = b;
          ph        = PH_DLEN;
        end
        PH_DLEN: begin
          dcount_hold = b;
          fcount      = '0;
          id_seen     = 1'b0;
          if (b == 8'd0) soft_end(r);
          else ph = PH_DEST;
        end
        PH_DEST: begin
          dest_crc = crc_step(dest_crc, b);
          if (b == own_node) id_seen = 1'b1;
          fcount++;
          if (fcount >= {8'd0, dcount_hold}) begin
            if (!id_seen) soft_end(r);
            else begin
              ph     = PH_LEN;
              fcount = '0;
            end
          end
        end
        PH_LEN: begin
          if (fcount == 16'd0) begin
            length_hold = {8'd0, b};
            fcount      = 16'd1;
          end else begin
            length_hold[15:8] = b;
            fcount            = '0;
            if (length_hold == 16'd0) final_check(r);  // empty payload: check now
            else ph = PH_DATA;
          end
        end
        default: begin
          r.payload_valid = 1'b1;
          r.payload_byte  = b;
          pay_crc = crc_step(pay_crc, b);
          fcount++;
          if (fcount >= length_hold) final_check(r);
        end
      endcase
    endfunction

    // predict the result of one accepted request
    function void note_request(mode_t m, logic [7:0] b);
      drd_result_t r;
      r = '0;
      if (m == MODE_ARM) begin
        if (link == LS_ACTIVE) r.response = RESP_BUSY;
        else armed = 1'b1;
      end else if (!armed) begin
        r.response = RESP_NOT_ARMED;
      end else if (m == MODE_START) begin
        if (link == LS_ACTIVE && !soft_done) r.response = RESP_BUSY;
        else begin
          link      = LS_ACTIVE;
          soft_done = 1'b0;
          clear_dgram();
        end
      end else if (link != LS_ACTIVE) begin
        r.response = RESP_NO_DGRAM;
      end else if (!soft_done) begin
        // after a soft end data is dropped and the timer is stopped
        if (m == MODE_TICK) begin
          if (idle_ticks != 16'hFFFF) idle_ticks++;
          if (idle_ticks >= timeout_ticks) begin
            armed = 1'b0;
            link  = LS_ERROR;
            close_dgram(r, VERDICT_TIMEOUT);
          end
        end else begin
          idle_ticks = '0;
          take_byte(b, r);
        end
      end
      pending_results.push_back(r);
    endfunction

    function string show(drd_result_t r);
      return $sformatf("resp=%0d pv=%0d pb=%02h fin=%0d vd=%0d type=%02h cnt=%02h len=%04h crc=%08h",
                       r.response, r.payload_valid, r.payload_byte, r.finished, r.verdict,
                       r.frame_type, r.dest_count, r.payload_length, r.crc_word);
    endfunction

    function void check_result(drd_result_t got);
      drd_result_t want;
      string       diff;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request pending: %s", show(got));
        return;
      end
      want = pending_results.pop_front();
      diff = "";
      if (got.response !== want.response) diff = {diff, " response"};
      if (got.payload_valid !== want.payload_valid) diff = {diff, " payload_valid"};
      if (got.payload_byte !== want.payload_byte) diff = {diff, " payload_byte"};
      if (got.finished !== want.finished) diff = {diff, " finished"};
      if (got.verdict !== want.verdict) diff = {diff, " verdict"};
      if (got.frame_type !== want.frame_type) diff = {diff, " frame_type"};
      if (got.dest_count !== want.dest_count) diff = {diff, " dest_count"};
      if (got.payload_length !== want.payload_length) diff = {diff, " payload_length"};
      if (got.crc_word !== want.crc_word) diff = {diff, " crc_word"};
      if (diff != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch in%s", diff);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // DUT hookup
  // -------------------------------------------------------------------------
  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  response;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        finished;
  logic [1:0]  verdict;
  logic [7:0]  frame_type;
  logic [7:0]  dest_count;
  logic [15:0] payload_length;
  logic [31:0] crc_word;
  logic        cfg_write_en;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  datagram_receive_deframer uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .response       (response),
    .payload_valid  (payload_valid),
    .payload_byte   (payload_byte),
    .finished       (finished),
    .verdict        (verdict),
    .frame_type     (frame_type),
    .dest_count     (dest_count),
    .payload_length (payload_length),
    .crc_word       (crc_word),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  dgram_scoreboard sb = new();

  int          sent_count   = 0;  // accepted requests
  int          burst_left   = 0;  // requests left in the current sender burst
  int          quiet_cycles = 0;  // cycles since anything was accepted
  bit          hold_off_req = 1'b0;
  drd_result_t got;

  // -------------------------------------------------------------------------
  // Result side: the sink stall pattern runs in segments, each with its own
  // stall rate (none at all in some). A hold-off request from the main flow
  // stalls for HOLD_CYCLES so the result register fills and in_stall rises.
  // -------------------------------------------------------------------------
  initial begin : result_sink
    int seg_left;
    int stall_pct;
    int hold_left;
    seg_left  = 0;
    stall_pct = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 80);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 80;
          endcase
        end
        seg_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Sample at the falling edge: everything the TB drives changed at the
  // rising edge and the DUT outputs are registered, so values are settled.
  // A result seen here with out_stall low is taken at the next rising edge.
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got.response       = resp_t'(response);
      got.payload_valid  = payload_valid;
      got.payload_byte   = payload_byte;
      got.finished       = finished;
      got.verdict        = verdict_t'(verdict);
      got.frame_type     = frame_type;
      got.dest_count     = dest_count;
      got.payload_length = payload_length;
      got.crc_word       = crc_word;
      sb.check_result(got);
    end
    if (!rst && ((in_valid && !in_stall) || (out_valid && !out_stall))) quiet_cycles = 0;
    else quiet_cycles++;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Request side. Every task is entered and left just after a rising edge.
  // -------------------------------------------------------------------------

  // One request. Sender works in bursts; between bursts valid drops for a
  // random gap (sometimes none, so bursts run back to back).
  task automatic send_req(input mode_t m, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    mode      <= m;
    data_byte <= b;
    do @(negedge clk); while (in_stall);
    @(posedge clk);  // request taken here
    sb.note_request(m, b);
    sent_count++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Only called with the block drained
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_regs(input logic [7:0] ver, input logic [7:0] node,
                          input logic [15:0] tmo);
    drain();
    write_reg(REG_EXP_VERSION, {8'd0, ver});
    write_reg(REG_OWN_NODE, {8'd0, node});
    write_reg(REG_TIMEOUT, tmo);
  endtask

  // Tick a stuck active datagram into timeout (small timeouts only)
  task automatic settle();
    while (sb.link == LS_ACTIVE && !sb.soft_done) send_req(MODE_TICK, 8'($urandom));
  endtask

  task automatic send_noise(input int count, input bit allow_start);
    mode_t m;
    repeat (count) begin
      m = mode_t'($urandom_range(0, 3));
      if (!allow_start && m == MODE_START) m = MODE_TICK;
      send_req(m, 8'($urandom));
    end
  endtask

  // Arm, start and one framed datagram. n_sel / len_sel < 0 pick at random.
  // rough allows stray starts inside the frame (small timeouts only, since
  // a restart mid-frame can leave a datagram open that only a timeout ends).
  task automatic send_dgram(input fault_t flt, input int n_sel, input int len_sel,
                            input bit rough);
    logic [7:0]  dests[$];
    logic [7:0]  body[$];
    logic [7:0]  frame[$];
    logic [7:0]  typ;
    logic [7:0]  n;
    logic [7:0]  d;
    logic [7:0]  ver;
    logic [15:0] len;
    logic [31:0] dcrc;
    logic [31:0] pcrc;
    logic [31:0] crc;
    int          cut;
    typ = 8'($urandom);
    if (flt == FLT_NO_DEST) n = 8'd0;
    else if (n_sel >= 0) n = 8'(n_sel);
    else n = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(6, 40))
                                         : 8'($urandom_range(1, 5));
    for (int i = 0; i < n; i++) begin
      d = 8'($urandom);
      if (flt == FLT_NOT_MINE && d == sb.own_node) d = d + 8'd1;
      dests.push_back(d);
    end
    if (flt != FLT_NOT_MINE && n != 8'd0) dests[$urandom_range(0, n - 1)] = sb.own_node;
    dcrc = CRC_INIT;
    foreach (dests[i]) dcrc = sb.crc_step(dcrc, dests[i]);

    if (len_sel >= 0) len = 16'(len_sel);
    else len = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(100, 300))
                                            : 16'($urandom_range(0, 12));
    pcrc = CRC_INIT;
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom);
      pcrc = sb.crc_step(pcrc, d);
      body.push_back(d);
    end

    crc = sb.frame_crc(typ, n, dcrc, len, pcrc);
    if (flt == FLT_CRC) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    ver = sb.exp_version;
    if (flt == FLT_VERSION) ver = ver + 8'($urandom_range(1, 255));

    // version, CRC (LE), type, count, ids, length (LE), payload
    frame.push_back(ver);
    for (int i = 0; i < 4; i++) frame.push_back(crc[8*i +: 8]);
    frame.push_back(typ);
    frame.push_back(n);
    foreach (dests[i]) frame.push_back(dests[i]);
    frame.push_back(len[7:0]);
    frame.push_back(len[15:8]);
    foreach (body[i]) frame.push_back(body[i]);

    cut = (flt == FLT_TRUNCATE) ? $urandom_range(0, frame.size() - 1) : frame.size();
    send_req(MODE_ARM, 8'($urandom));
    send_req(MODE_START, 8'($urandom));
    for (int i = 0; i < cut; i++) begin
      // the odd tick between bytes; the byte after it clears the count
      if ($urandom_range(0, 29) == 0) send_req(MODE_TICK, 8'($urandom));
      // stray arm or start: refused while busy, a start restarts after soft end
      if ($urandom_range(0, 59) == 0) begin
        if (rough && $urandom_range(0, 1) == 0) send_req(MODE_START, 8'($urandom));
        else send_req(MODE_ARM, 8'($urandom));
      end
      send_req(MODE_DATA, frame[i]);
    end
  endtask

  // Mostly well-formed datagrams with random content, some damaged,
  // with bursts of random requests between them
  task automatic run_traffic(input int items);
    int     stop;
    int     pick;
    bit     rough;
    fault_t flt;
    stop  = sent_count + items;
    rough = (sb.timeout_ticks <= 16'd64);
    while (sent_count < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) flt = FLT_NONE;
      else if (pick < 63) flt = FLT_VERSION;
      else if (pick < 70) flt = FLT_NO_DEST;
      else if (pick < 78) flt = FLT_NOT_MINE;
      else if (pick < 88) flt = FLT_CRC;
      else flt = rough ? FLT_TRUNCATE : FLT_CRC;
      send_dgram(flt, -1, -1, rough);
      if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 6), rough);
      if (rough) settle();
    end
  endtask

  // -------------------------------------------------------------------------
  // Main flow
  // -------------------------------------------------------------------------
  initial begin : main_flow
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    mode         <= MODE_DATA;
    data_byte    <= 8'd0;
    cfg_write_en <= 1'b0;
    cfg_index    <= REG_EXP_VERSION;
    cfg_data     <= 16'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // --- reset register values: version 1, node 0, timeout 25 ---
    // nothing is armed yet
    send_req(MODE_DATA, 8'hFF);
    send_req(MODE_START, 8'h00);
    send_req(MODE_TICK, 8'h00);
    // armed, but no datagram open
    send_req(MODE_ARM, 8'h00);
    send_req(MODE_DATA, 8'h00);
    send_req(MODE_TICK, 8'hFF);
    // open datagram refuses arm and start
    send_req(MODE_START, 8'h00);
    send_req(MODE_ARM, 8'h00);
    send_req(MODE_START, 8'h00);
    // good frame with empty payload: CRC check on the second length byte
    send_dgram(FLT_NONE, 1, 0, 1'b0);
    // soft end, then dropped data, stopped timer, refused arm
    send_dgram(FLT_VERSION, -1, 4, 1'b0);
    send_req(MODE_DATA, 8'hA5);
    send_req(MODE_TICK, 8'h00);
    send_req(MODE_ARM, 8'h00);
    // start accepted after soft end; zero destination count
    send_dgram(FLT_NO_DEST, -1, 0, 1'b0);
    send_dgram(FLT_CRC, -1, 2, 1'b0);
    send_dgram(FLT_TRUNCATE, -1, -1, 1'b1);
    settle();
    run_traffic(120);

    // --- extremes: version/node all ones, timeout zero acts as one ---
    set_regs(8'hFF, 8'hFF, 16'd0);
    send_req(MODE_ARM, 8'h00);
    send_req(MODE_START, 8'h00);
    send_req(MODE_DATA, sb.exp_version);
    send_req(MODE_TICK, 8'h00);  // first idle tick times out
    run_traffic(100);

    // --- version zero, shortest nonzero timeout ---
    set_regs(8'h00, 8'($urandom_range(1, 254)), 16'd1);
    run_traffic(100);

    // --- longest timeout; one longer frame with several ids ---
    set_regs(8'($urandom), 8'($urandom), 16'hFFFF);
    send_dgram(FLT_NONE, 8, 24, 1'b0);
    run_traffic(120);

    // --- sink holds off while the sender keeps offering ---
    set_regs(8'd1, 8'h5A, 16'd3);
    hold_off_req = 1'b1;
    run_traffic(150);

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
